// File: sv/tcgr_pkg.sv
// Shared types, codes and helpers of the text console glyph renderer.
`default_nettype none

package tcgr_pkg;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Character codes handled by the cursor logic.
    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Input mode codes.
    localparam logic MODE_PRINT   = 1'b0;
    localparam logic MODE_FONT_WR = 1'b1;

    // Result kind codes.
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    typedef enum logic [2:0] {
        CFG_ENABLE  = 3'd0,
        CFG_COLUMNS = 3'd1,
        CFG_ROWS    = 3'd2,
        CFG_FORE    = 3'd3,
        CFG_BACK    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_FONT_WR = 2'd0,
        CMD_DRAW    = 2'd1,
        CMD_SCROLL  = 2'd2
    } t_cmd_op;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_ROWS   = 2'd1,
        ST_SCROLL = 2'd2
    } t_back_state;

    typedef struct packed {
        logic        enable;
        logic [8:0]  columns;
        logic [8:0]  rows;
        logic [23:0] fore;
        logic [23:0] back;
    } t_cfg;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        t_cmd_op     op;
        logic [7:0]  code;
        logic [3:0]  font_row;
        logic [7:0]  font_bits;
        logic [7:0]  col;
        logic [7:0]  line;
        logic        scroll;
        logic [11:0] scroll_y;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // A geometry register of zero counts as one, anything above 256 as 256.
    function automatic logic [8:0] clamp_geom(input logic [8:0] v);
        logic [8:0] res;
        res = v;
        if (v == 9'd0) begin
            res = 9'd1;
        end else if (v > 9'd256) begin
            res = 9'd256;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/tcgr_if.sv
// Handshake channel interfaces of the text console glyph renderer.
`default_nettype none

interface tcgr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] char_code;
    logic [3:0] font_row;
    logic [7:0] font_bits;

    modport source(output valid, mode, char_code, font_row, font_bits, input ready);
    modport sink(input valid, mode, char_code, font_row, font_bits, output ready);
endinterface

interface tcgr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  glyph_bits;
    logic [23:0] fore_pixel;
    logic [23:0] back_pixel;
    logic        last;

    modport source(output valid, kind, pixel_x, pixel_y, glyph_bits, fore_pixel,
                   back_pixel, last, input ready);
    modport sink(input valid, kind, pixel_x, pixel_y, glyph_bits, fore_pixel,
                 back_pixel, last, output ready);
endinterface

interface tcgr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/text_console_glyph_renderer_top.sv
// Top level of the text console glyph renderer: configuration registers and part wiring.
//
// The block takes one request at a time on i_req. A print request of an ordinary
// character gives GLYPH_HEIGHT draw results, one for each glyph row, plus one scroll
// result when the cursor runs past the last text line; newline and carriage return give
// only that scroll result when one is due. Font writes, disabled prints and line moves
// without scrolling give no result. The front part updates the cursor in the cycle the
// request is taken and places the work in a four-entry queue, so it keeps taking requests
// while the back part drains and the queue is not full. The back part reads the font
// memory through its single read port, one glyph row a cycle while o_res does not stall,
// so a printed character takes one step per glyph row plus one for a scroll, and a font
// write is done as it leaves the queue. Stalls on o_res hold the row sequencer, but an
// idle back part still takes commands from the queue. The font memory has no reset and
// no clearing pass: glyphs must be written before they are printed. Configuration writes
// are taken at any time through i_cfg and are meant to come only while the block is
// idle.
`default_nettype none

module text_console_glyph_renderer_top #(
    parameter int GLYPH_HEIGHT = 16,
    parameter int FONT_CHARS   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcgr_in_if.sink     i_req,
    tcgr_out_if.source  o_res,
    tcgr_cfg_if.sink    i_cfg
);
    import tcgr_pkg::*;

    t_cfg      r_cfg;
    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_q_status q_stat;
    logic      q_push;
    logic      q_pop;

    // The register file never stalls a write.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable  <= 1'b0;
            r_cfg.columns <= 9'd80;
            r_cfg.rows    <= 9'd25;
            r_cfg.fore    <= 24'hFFFFFF;
            r_cfg.back    <= 24'h000000;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_ENABLE:  r_cfg.enable  <= i_cfg.data[0];
                CFG_COLUMNS: r_cfg.columns <= i_cfg.data[8:0];
                CFG_ROWS:    r_cfg.rows    <= i_cfg.data[8:0];
                CFG_FORE:    r_cfg.fore    <= i_cfg.data;
                CFG_BACK:    r_cfg.back    <= i_cfg.data;
                default: begin
                    // Indexes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Front part: takes requests and keeps the cursor.
    tcgr_front #(
        .GLYPH_HEIGHT(GLYPH_HEIGHT),
        .FONT_CHARS  (FONT_CHARS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .i_q_stat(q_stat),
        .o_push  (q_push),
        .o_cmd   (front_cmd)
    );

    // Queue that lets the two parts stall independently.
    tcgr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (front_cmd),
        .i_pop  (q_pop),
        .o_cmd  (queue_cmd),
        .o_stat (q_stat)
    );

    // Back part: font memory and result sequencing.
    tcgr_back #(
        .GLYPH_HEIGHT(GLYPH_HEIGHT),
        .FONT_CHARS  (FONT_CHARS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_q_stat(q_stat),
        .o_pop   (q_pop),
        .i_cfg   (r_cfg),
        .o_res   (o_res)
    );

    // The front must never push into a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    // The back must never take a command from an empty queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) q_pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    // A scroll result always closes the request that caused it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_SCROLL)) |-> o_res.last)
        else $error("scroll result without last");

    // A scroll result carries no glyph and starts at the left edge.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_SCROLL))
            |-> ((o_res.pixel_x == 11'd0) && (o_res.glyph_bits == 8'd0)))
        else $error("scroll result with pixel data");

endmodule

`default_nettype wire

// File: sv/tcgr_front.sv
// Front part: accepts requests, moves the cursor and queues the work to do.
`default_nettype none

module tcgr_front #(
    parameter int GLYPH_HEIGHT = 16,
    parameter int FONT_CHARS   = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tcgr_in_if.sink              i_req,
    input  tcgr_pkg::t_cfg       i_cfg,
    input  tcgr_pkg::t_q_status  i_q_stat,
    output logic                 o_push,
    output tcgr_pkg::t_cmd       o_cmd
);
    import tcgr_pkg::*;

    logic [7:0] r_cur_col, n_cur_col;
    logic [7:0] r_cur_row, n_cur_row;

    logic       accept;
    logic [8:0] cols, rows;
    logic [7:0] rows_m1;
    logic       is_nl, is_cr, is_glyph;
    logic [8:0] col9, line9;
    logic       wrap;
    logic [9:0] line10;
    logic       scroll;
    logic [7:0] moved_col, moved_row;
    logic       font_ok;

    assign i_req.ready = !i_q_stat.full;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        cols     = clamp_geom(i_cfg.columns);
        rows     = clamp_geom(i_cfg.rows);
        rows_m1  = 8'(rows - 9'd1);
        is_nl    = (i_req.char_code == CHAR_NL);
        is_cr    = (i_req.char_code == CHAR_CR);
        is_glyph = !is_nl && !is_cr;
        col9     = is_glyph ? ({1'b0, r_cur_col} + 9'd1) : 9'd0;
        line9    = is_nl ? ({1'b0, r_cur_row} + 9'd1) : {1'b0, r_cur_row};
        wrap     = (col9 >= cols);
        line10   = {1'b0, line9} + {9'd0, wrap};
        scroll   = (line10 >= {1'b0, rows});
        moved_row = scroll ? rows_m1 : line10[7:0];
        moved_col = wrap ? 8'd0 : col9[7:0];
        font_ok  = ({1'b0, i_req.char_code} < 9'(FONT_CHARS))
                   && (6'(i_req.font_row) < 6'(GLYPH_HEIGHT));

        o_cmd.op        = is_glyph ? CMD_DRAW : CMD_SCROLL;
        o_cmd.code      = i_req.char_code;
        o_cmd.font_row  = i_req.font_row;
        o_cmd.font_bits = i_req.font_bits;
        o_cmd.col       = r_cur_col;
        o_cmd.line      = r_cur_row;
        o_cmd.scroll    = scroll;
        o_cmd.scroll_y  = 12'(int'(rows_m1) * GLYPH_HEIGHT);

        o_push    = 1'b0;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (accept) begin
            if (i_req.mode == MODE_FONT_WR) begin
                o_cmd.op = CMD_FONT_WR;
                o_push   = font_ok;
            end else if (i_cfg.enable) begin
                n_cur_col = moved_col;
                n_cur_row = moved_row;
                o_push    = is_glyph || scroll;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= 8'd0;
            r_cur_row <= 8'd0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
        end
    end

endmodule

`default_nettype wire

// File: sv/tcgr_queue.sv
// Short command queue between the front and back parts.
`default_nettype none

module tcgr_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcgr_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output tcgr_pkg::t_cmd       o_cmd,
    output tcgr_pkg::t_q_status  o_stat
);
    import tcgr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_cmd        = r_slots[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/tcgr_back.sv
// Back part: font memory, glyph row sequencer and the result register.
`default_nettype none

module tcgr_back #(
    parameter int GLYPH_HEIGHT = 16,
    parameter int FONT_CHARS   = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcgr_pkg::t_cmd       i_cmd,
    input  tcgr_pkg::t_q_status  i_q_stat,
    output logic                 o_pop,
    input  tcgr_pkg::t_cfg       i_cfg,
    tcgr_out_if.source           o_res
);
    import tcgr_pkg::*;

    localparam int ROW_W  = $clog2(GLYPH_HEIGHT);
    localparam int DEPTH  = FONT_CHARS * GLYPH_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rdata;

    t_back_state       r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    t_cmd              r_cmd;

    // Read stage: the request whose font byte is being fetched.
    logic              r_s1_valid;
    logic              r_s1_kind;
    logic [10:0]       r_s1_px;
    logic [11:0]       r_s1_py;
    logic              r_s1_zero;
    logic              r_s1_last;

    // Result register.
    logic              r_o_valid;
    logic              r_o_kind;
    logic [10:0]       r_o_px;
    logic [11:0]       r_o_py;
    logic [7:0]        r_o_bits;
    logic              r_o_last;

    logic              adv;
    logic              finishing;
    logic              load;
    logic              mem_we;
    logic              rd_en;
    logic              code_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              iss_valid;
    logic              iss_kind;
    logic [10:0]       iss_px;
    logic [11:0]       iss_py;
    logic              iss_zero;
    logic              iss_last;

    assign adv     = !(r_o_valid && !o_res.ready);
    assign code_ok = ({1'b0, r_cmd.code} < 9'(FONT_CHARS));
    assign rd_addr = code_ok ? ADDR_W'(int'(r_cmd.code) * GLYPH_HEIGHT + int'(r_row)) : '0;
    assign wr_addr = ADDR_W'(int'(i_cmd.code) * GLYPH_HEIGHT + int'(i_cmd.font_row));

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        finishing = 1'b0;
        load      = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        o_pop     = 1'b0;
        iss_valid = 1'b0;
        iss_kind  = KIND_DRAW;
        iss_px    = {r_cmd.col, 3'b000};
        iss_py    = 12'(int'(r_cmd.line) * GLYPH_HEIGHT + int'(r_row));
        iss_zero  = !code_ok;
        iss_last  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_ROWS: begin
                if (adv) begin
                    iss_valid = 1'b1;
                    rd_en     = 1'b1;
                    iss_last  = (r_row == LAST_ROW) && !r_cmd.scroll;
                    n_row     = r_row + 1'b1;
                    if (r_row == LAST_ROW) begin
                        if (r_cmd.scroll) begin
                            n_state = ST_SCROLL;
                        end else begin
                            finishing = 1'b1;
                        end
                    end
                end
            end
            ST_SCROLL: begin
                if (adv) begin
                    iss_valid = 1'b1;
                    iss_kind  = KIND_SCROLL;
                    iss_px    = 11'd0;
                    iss_py    = r_cmd.scroll_y;
                    iss_zero  = 1'b1;
                    iss_last  = 1'b1;
                    finishing = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (finishing) begin
            n_state = ST_IDLE;
        end

        // The next command is taken as soon as the current one has issued its last slot.
        if (((r_state == ST_IDLE) || finishing) && !i_q_stat.empty) begin
            o_pop = 1'b1;
            unique case (i_cmd.op)
                CMD_FONT_WR: begin
                    mem_we = 1'b1;
                end
                CMD_DRAW: begin
                    load    = 1'b1;
                    n_state = ST_ROWS;
                    n_row   = '0;
                end
                CMD_SCROLL: begin
                    load    = 1'b1;
                    n_state = ST_SCROLL;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_cmd.font_bits;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_s1_kind <= iss_kind;
            r_s1_px   <= iss_px;
            r_s1_py   <= iss_py;
            r_s1_zero <= iss_zero;
            r_s1_last <= iss_last;
            r_o_kind  <= r_s1_kind;
            r_o_px    <= r_s1_px;
            r_o_py    <= r_s1_py;
            r_o_bits  <= r_s1_zero ? 8'd0 : r_rdata;
            r_o_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= iss_valid;
            r_o_valid  <= r_s1_valid;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.kind       = r_o_kind;
    assign o_res.pixel_x    = r_o_px;
    assign o_res.pixel_y    = r_o_py;
    assign o_res.glyph_bits = r_o_bits;
    assign o_res.fore_pixel = i_cfg.fore;
    assign o_res.back_pixel = i_cfg.back;
    assign o_res.last       = r_o_last;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench of the text console glyph renderer with a cycle-free console predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcgr_pkg::*;

    // The block is built with the default 8x16 font geometry.
    localparam int GLYPH_H = 16;
    localparam int FONT_N  = 256;

    // Once nothing is expected, queued font writes may still occupy the back
    // part.  This many quiet cycles is more than enough before a register
    // write, a forced drain, or the end of the run.
    localparam int SETTLE = 24;

    // What one entry of the stimulus script asks the driver to do.
    typedef enum logic [1:0] {
        ACT_SEND,
        ACT_REG_WR,
        ACT_DRAIN
    } step_kind_e;

    typedef struct {
        step_kind_e  act;
        logic        mode;
        logic [7:0]  code;
        logic [3:0]  frow;
        logic [7:0]  fbits;
        t_cfg_idx    reg_idx;
        logic [23:0] reg_data;
        bit          calm;
    } stim_t;

    // One draw or scroll request expected on the output channel.
    typedef struct packed {
        logic        kind;
        logic [10:0] px;
        logic [11:0] py;
        logic [7:0]  glyph;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        is_last;
    } stroke_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcgr_in_if  req_if ();
    tcgr_out_if res_if ();
    tcgr_cfg_if cfg_if ();

    text_console_glyph_renderer_top #(
        .GLYPH_HEIGHT(GLYPH_H),
        .FONT_CHARS  (FONT_N)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Script of pending requests, register writes and drain points, filled once at time zero.
    stim_t   console_script[$];
    // Draw and scroll requests still owed by the block, oldest first.
    stroke_t expected_draws[$];

    // Console state as the predictor sees it.
    logic        reg_enable;
    logic [8:0]  reg_cols;
    logic [8:0]  reg_rows;
    logic [23:0] reg_fg;
    logic [23:0] reg_bg;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [7:0]  glyph_mem [0:FONT_N*GLYPH_H-1];

    // Generation-time view: which glyphs are fully written and safe to print.
    bit          glyph_loaded [0:FONT_N-1];
    logic [7:0]  loaded_codes[$];
    bit          gen_enabled;
    bit          gen_calm;

    // Calm flag of the request last sent; it suppresses output stalls (each entry's own flag suppresses its send gap).
    bit steady = 1'b0;
    int idle_run;
    int mismatches = 0;
    int requests_taken = 0;
    int reg_writes = 0;
    int draws_seen = 0;
    int scrolls_seen = 0;

    // Predict the outcome of one accepted request and queue the results it causes.
    task automatic emulate_console(input logic mode, input logic [7:0] code,
                                   input logic [3:0] frow, input logic [7:0] fbits);
        int unsigned cols;
        int unsigned rows;
        int unsigned col;
        int unsigned line;
        stroke_t     s;
        stroke_t     burst[$];
        if (mode == MODE_FONT_WR) begin
            // A font write never produces output, enabled or not.
            glyph_mem[{code, frow}] = fbits;
            return;
        end
        if (!reg_enable) begin
            return;
        end
        // Zero geometry behaves like one, anything past 256 like 256.
        cols = (reg_cols == 9'd0) ? 1 : (reg_cols > 9'd256) ? 256 : reg_cols;
        rows = (reg_rows == 9'd0) ? 1 : (reg_rows > 9'd256) ? 256 : reg_rows;
        col  = cur_col;
        line = cur_row;
        s.fg = reg_fg;
        s.bg = reg_bg;
        s.is_last = 1'b0;
        if (code == CHAR_NL) begin
            col  = 0;
            line = line + 1;
        end else if (code == CHAR_CR) begin
            col = 0;
        end else begin
            // The glyph lands at the cursor even when the cursor sits outside a
            // geometry that shrank after it got there.
            for (int r = 0; r < GLYPH_H; r++) begin
                s.kind  = KIND_DRAW;
                s.px    = 11'(col * 8);
                s.py    = 12'(line * GLYPH_H + r);
                s.glyph = glyph_mem[{code, 4'(r)}];
                burst.push_back(s);
            end
            col = col + 1;
        end
        if (col >= cols) begin
            col  = 0;
            line = line + 1;
        end
        if (line >= rows) begin
            s.kind  = KIND_SCROLL;
            s.px    = '0;
            s.py    = 12'((rows - 1) * GLYPH_H);
            s.glyph = '0;
            burst.push_back(s);
            line = rows - 1;
        end
        cur_col = col[7:0];
        cur_row = line[7:0];
        if (burst.size() != 0) begin
            burst[burst.size()-1].is_last = 1'b1;
        end
        foreach (burst[i]) begin
            expected_draws.push_back(burst[i]);
        end
    endtask

    task automatic cmp_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Script builders used by the stimulus block.
    task automatic queue_send(input logic mode, input logic [7:0] code,
                              input logic [3:0] frow, input logic [7:0] fbits);
        stim_t st;
        st.act      = ACT_SEND;
        st.mode     = mode;
        st.code     = code;
        st.frow     = frow;
        st.fbits    = fbits;
        st.reg_idx  = CFG_ENABLE;
        st.reg_data = '0;
        st.calm     = gen_calm;
        console_script.push_back(st);
    endtask

    // Row and bitmap fields are don't-care in a print request, so they carry noise.
    task automatic queue_print(input logic [7:0] code);
        queue_send(MODE_PRINT, code, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_reg(input t_cfg_idx idx, input logic [23:0] data);
        stim_t st;
        st.act      = ACT_REG_WR;
        st.mode     = MODE_PRINT;
        st.code     = '0;
        st.frow     = '0;
        st.fbits    = '0;
        st.reg_idx  = idx;
        st.reg_data = data;
        st.calm     = gen_calm;
        console_script.push_back(st);
        if (idx == CFG_ENABLE) begin
            gen_enabled = data[0];
        end
    endtask

    // The sender holds off until every owed result has come back.
    task automatic queue_drain();
        stim_t st;
        st.act      = ACT_DRAIN;
        st.mode     = MODE_PRINT;
        st.code     = '0;
        st.frow     = '0;
        st.fbits    = '0;
        st.reg_idx  = CFG_ENABLE;
        st.reg_data = '0;
        st.calm     = gen_calm;
        console_script.push_back(st);
    endtask

    // Write all sixteen rows of one glyph; solid or empty rows show up now and then.
    task automatic load_glyph(input logic [7:0] code);
        logic [7:0] bits;
        for (int r = 0; r < GLYPH_H; r++) begin
            bits = ($urandom_range(0, 3) == 0) ? {8{r[0]}} : 8'($urandom_range(0, 255));
            queue_send(MODE_FONT_WR, code, 4'(r), bits);
        end
        if (!glyph_loaded[code]) begin
            glyph_loaded[code] = 1'b1;
            loaded_codes.push_back(code);
        end
    endtask

    function automatic logic [7:0] pick_glyph();
        return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
    endfunction

    // Mostly small screens so that wrapping and scrolling come often.
    function automatic logic [8:0] pick_geom();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [23:0] pick_colour();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // Driver: takes script entries one at a time.  Requests go out on i_req with
    // random gaps, register writes and drain points wait until the block is quiet.
    // Every accepted request is handed to the predictor at the edge it is taken.
    always @(posedge i_clk) begin : drive_p
        stim_t nxt;
        bit    req_hold;
        bit    cfg_hold;
        bit    send_now;
        bit    cfg_now;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            cfg_if.valid <= 1'b0;
            idle_run     <= 0;
            reg_enable = 1'b0;
            reg_cols   = 9'd80;
            reg_rows   = 9'd25;
            reg_fg     = 24'hFFFFFF;
            reg_bg     = 24'h000000;
            cur_col    = '0;
            cur_row    = '0;
        end else begin
            req_hold = req_if.valid && !req_if.ready;
            cfg_hold = cfg_if.valid && !cfg_if.ready;
            if (req_if.valid && req_if.ready) begin
                emulate_console(req_if.mode, req_if.char_code, req_if.font_row,
                                req_if.font_bits);
                requests_taken++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (t_cfg_idx'(cfg_if.index))
                    CFG_ENABLE:  reg_enable = cfg_if.data[0];
                    CFG_COLUMNS: reg_cols   = cfg_if.data[8:0];
                    CFG_ROWS:    reg_rows   = cfg_if.data[8:0];
                    CFG_FORE:    reg_fg     = cfg_if.data;
                    CFG_BACK:    reg_bg     = cfg_if.data;
                    default: ;
                endcase
                reg_writes++;
            end
            // Count quiet cycles: nothing in flight and nothing owed.
            if (req_if.valid || expected_draws.size() != 0) begin
                idle_run <= 0;
            end else begin
                idle_run <= idle_run + 1;
            end
            if (!req_hold && !cfg_hold) begin
                send_now = 1'b0;
                cfg_now  = 1'b0;
                if (console_script.size() != 0) begin
                    nxt = console_script[0];
                    case (nxt.act)
                        ACT_SEND: begin
                            if (nxt.calm || $urandom_range(0, 99) >= 35) begin
                                void'(console_script.pop_front());
                                req_if.mode      <= nxt.mode;
                                req_if.char_code <= nxt.code;
                                req_if.font_row  <= nxt.frow;
                                req_if.font_bits <= nxt.fbits;
                                steady           <= nxt.calm;
                                send_now = 1'b1;
                            end
                        end
                        ACT_REG_WR: begin
                            if (idle_run >= SETTLE) begin
                                void'(console_script.pop_front());
                                cfg_if.index <= nxt.reg_idx;
                                cfg_if.data  <= nxt.reg_data;
                                cfg_now = 1'b1;
                            end
                        end
                        default: begin
                            if (idle_run >= SETTLE) begin
                                void'(console_script.pop_front());
                            end
                        end
                    endcase
                end
                req_if.valid <= send_now;
                cfg_if.valid <= cfg_now;
            end
        end
    end

    // Monitor: stalls the output at random and checks every taken result against
    // the oldest owed one, field by field.
    always @(posedge i_clk) begin : check_p
        stroke_t want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= steady || ($urandom_range(0, 99) >= 35);
            if (res_if.valid && res_if.ready) begin
                if (expected_draws.size() == 0) begin
                    $error("unexpected result: kind %0d x %0d y %0d bits 0x%0h",
                           res_if.kind, res_if.pixel_x, res_if.pixel_y, res_if.glyph_bits);
                    mismatches++;
                end else begin
                    want = expected_draws.pop_front();
                    cmp_field("kind", 24'(want.kind), 24'(res_if.kind));
                    cmp_field("pixel_x", 24'(want.px), 24'(res_if.pixel_x));
                    cmp_field("pixel_y", 24'(want.py), 24'(res_if.pixel_y));
                    cmp_field("glyph_bits", 24'(want.glyph), 24'(res_if.glyph_bits));
                    cmp_field("fore_pixel", want.fg, res_if.fore_pixel);
                    cmp_field("back_pixel", want.bg, res_if.back_pixel);
                    cmp_field("last", 24'(want.is_last), 24'(res_if.last));
                    if (want.kind == KIND_SCROLL) begin
                        scrolls_seen++;
                    end else begin
                        draws_seen++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stim_p
        int choice;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_PRINT;
        req_if.char_code = '0;
        req_if.font_row  = '0;
        req_if.font_bits = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_ENABLE;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        gen_enabled      = 1'b0;
        gen_calm         = 1'b0;
        foreach (glyph_loaded[i]) begin
            glyph_loaded[i] = 1'b0;
        end

        // Directed part.  After reset the console is off, so prints of any code,
        // even one with no glyph yet, are dropped without output.
        queue_print(8'h41);
        queue_print(CHAR_NL);
        // Font writes are taken while the console is off.  Codes at both ends
        // of the range and around the sign bit get glyphs.
        load_glyph(8'h00);
        load_glyph(8'hFF);
        load_glyph(8'h80);
        load_glyph(8'h7F);
        // A three-by-two screen: the third glyph wraps, the sixth wraps past
        // the last line and ends in a scroll.  Carriage return stays silent and
        // newline on the last line gives only a scroll.
        queue_reg(CFG_ENABLE, 24'd1);
        queue_reg(CFG_COLUMNS, 24'd3);
        queue_reg(CFG_ROWS, 24'd2);
        queue_reg(CFG_FORE, 24'hFFFFFF);
        queue_reg(CFG_BACK, 24'h000000);
        queue_print(8'h00);
        queue_print(8'hFF);
        queue_print(8'h80);
        queue_print(8'h7F);
        queue_print(8'h00);
        queue_print(8'hFF);
        queue_print(CHAR_CR);
        queue_print(CHAR_NL);
        // Zero geometry acts as a one-by-one screen.  The cursor is left on
        // line one, below that screen, so the glyph is drawn there first and
        // then the line scrolls.
        queue_reg(CFG_COLUMNS, 24'd0);
        queue_reg(CFG_ROWS, 24'd0);
        queue_reg(CFG_FORE, 24'h000000);
        queue_reg(CFG_BACK, 24'hFFFFFF);
        queue_print(8'h80);
        queue_print(CHAR_CR);
        queue_print(CHAR_NL);
        // Oversized geometry clamps to 256, and a glyph row rewritten just
        // before the print must show up in it.
        queue_reg(CFG_COLUMNS, 24'h1FF);
        queue_reg(CFG_ROWS, 24'h1FF);
        queue_print(8'h7F);
        queue_send(MODE_FONT_WR, 8'h00, 4'hF, 8'h5A);
        queue_print(8'h00);
        queue_drain();

        // Random part: several phases, each on its own screen setup.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 3) begin
                // Walk the cursor down to the bottom line of a tall screen,
                // draw there, then scroll it.  Later phases shrink the
                // screen under that cursor.
                gen_calm = 1'b0;
                queue_reg(CFG_ENABLE, 24'd1);
                queue_reg(CFG_COLUMNS, 24'd256);
                queue_reg(CFG_ROWS, 24'd40);
                repeat (39) begin
                    queue_print(CHAR_NL);
                end
                queue_print(pick_glyph());
                queue_print(CHAR_NL);
            end
            // Phase two runs without any idling on either side.
            gen_calm = (ph == 2);
            queue_reg(CFG_ENABLE, 24'(($urandom_range(0, 5) != 0) ? 1 : 0));
            queue_reg(CFG_COLUMNS, 24'(pick_geom()));
            queue_reg(CFG_ROWS, 24'(pick_geom()));
            queue_reg(CFG_FORE, pick_colour());
            queue_reg(CFG_BACK, pick_colour());
            repeat ((ph == 2) ? 30 : 11) begin
                choice = $urandom_range(0, 99);
                if (choice < 60) begin
                    // Unwritten glyphs are printed only while output is off.
                    if (gen_enabled) begin
                        queue_print(pick_glyph());
                    end else begin
                        queue_print(8'($urandom_range(0, 255)));
                    end
                end else if (choice < 70) begin
                    queue_print(CHAR_NL);
                end else if (choice < 76) begin
                    queue_print(CHAR_CR);
                end else if (choice < 86) begin
                    queue_send(MODE_FONT_WR, pick_glyph(), 4'($urandom_range(0, 15)),
                               8'($urandom_range(0, 255)));
                end else if (choice < 92) begin
                    queue_send(MODE_FONT_WR, 8'($urandom_range(0, 255)),
                               4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                end else if (choice < 96) begin
                    load_glyph(8'($urandom_range(0, 255)));
                end else begin
                    queue_drain();
                end
            end
        end
        gen_calm = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let the script run dry, collect everything owed, then watch a while
        // longer for anything the block sends beyond that.
        while (console_script.size() != 0 || req_if.valid || cfg_if.valid) begin
            @(posedge i_clk);
        end
        while (expected_draws.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4 * SETTLE) @(posedge i_clk);
        if (expected_draws.size() != 0) begin
            $error("%0d results never arrived", expected_draws.size());
            mismatches++;
        end

        $display("Run covered %0d requests and %0d register writes over several screen setups,",
                 requests_taken, reg_writes);
        $display("checking %0d glyph rows and %0d scrolls; %0d mismatches.",
                 draws_seen, scrolls_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS text_console_glyph_renderer_top");
        end else begin
            $display("FAIL text_console_glyph_renderer_top");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #400000;
        $display("FAIL text_console_glyph_renderer_top");
        $finish;
    end

endmodule
